/* sv/jsi_pkg.sv */
// ----------------------------------------------------------------------------
// Jog setpoint integrator package
// Shared widths, register indexes, reset values, codes and the command
// struct that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package jsi_pkg;

    localparam int JOINTS      = 4;
    localparam int ANGLE_W     = 16;
    localparam int AXIS_W      = 16;
    localparam int RATE_W      = 16;
    localparam int TIME_W      = 22;
    localparam int DT_W        = 18;
    localparam int RDT_W       = RATE_W + DT_W;
    localparam int PART_W      = 17;
    localparam int STEP_W      = 15;
    localparam int MASK_W      = JOINTS;
    localparam int SEL_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 22;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = JOINTS * ANGLE_W;
    localparam int M_TUSER_W   = 2;

    localparam logic [TIME_W-1:0] DT_LIMIT   = 22'd209715;
    localparam logic [DT_W-1:0]   DT_DEFAULT = 18'd20972;
    localparam logic [TIME_W-1:0] TIME_MAX   = 22'd4194303;

    localparam logic [RATE_W-1:0]        RATE_RST   = 16'd4096;
    localparam logic signed [ANGLE_W-1:0] AMIN_RST  = -16'sd5939;
    localparam logic signed [ANGLE_W-1:0] AMAX_RST  = 16'sd5939;
    localparam logic [AXIS_W-1:0]        DBAND_RST  = 16'd6554;
    localparam logic [TIME_W-1:0]        PERIOD_RST = 22'd209715;
    localparam logic [MASK_W-1:0]        MASK_RST   = 4'd10;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE        = 3'd0,
        REG_ANGLE_MIN   = 3'd1,
        REG_ANGLE_MAX   = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_SEND_PERIOD = 3'd4,
        REG_MIRROR_MASK = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_REPORT = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RDT,
        MUL_FLO,
        MUL_FHI,
        MUL_RLO,
        MUL_RHI
    } mul_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDT,
        S_FLO,
        S_FHI,
        S_RLO,
        S_RHI,
        S_RSUM,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic    capture;
        mul_op_t mul_op;
        logic    front_sum;
        logic    rear_sum;
        logic    commit;
    } dp_cmd_t;

endpackage

/* sv/jsi_ctrl.sv */
// ----------------------------------------------------------------------------
// Jog setpoint integrator controller
// Sequences one request at a time through the shared multiplier steps and
// holds the result valid flag until the result has been taken.
// ----------------------------------------------------------------------------
module jsi_ctrl
    import jsi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  func_t   s_func,
    output logic    s_tready,
    input  logic    m_tready,
    output logic    m_tvalid,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '{capture: 1'b0, mul_op: MUL_NONE, front_sum: 1'b0,
                       rear_sum: 1'b0, commit: 1'b0};
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_func == FUNC_REPORT) ? S_APPLY : S_RDT;
                end
            end
            S_RDT: begin
                cmd.mul_op = MUL_RDT;
                state_next = S_FLO;
            end
            S_FLO: begin
                cmd.mul_op = MUL_FLO;
                state_next = S_FHI;
            end
            S_FHI: begin
                cmd.mul_op = MUL_FHI;
                state_next = S_RLO;
            end
            S_RLO: begin
                cmd.mul_op    = MUL_RLO;
                cmd.front_sum = 1'b1;
                state_next    = S_RHI;
            end
            S_RHI: begin
                cmd.mul_op = MUL_RHI;
                state_next = S_RSUM;
            end
            S_RSUM: begin
                cmd.rear_sum = 1'b1;
                state_next   = S_APPLY;
            end
            S_APPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_tvalid) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start processing");

    a_apply_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && m_tvalid_reg && !m_tready)
        |=> (state_reg == S_APPLY && m_tvalid_reg))
        else $error("result overwritten before it was taken");

    a_valid_from_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_APPLY))
        else $error("result valid raised outside the apply step");

endmodule

/* sv/jsi_dp.sv */
// ----------------------------------------------------------------------------
// Jog setpoint integrator datapath
// Holds the configuration, measurements and targets, one shared multiplier
// for the step sizes, and the update of targets and send timing.
// ----------------------------------------------------------------------------
module jsi_dp
    import jsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser
);

    // Configuration registers.
    logic [RATE_W-1:0] rate_reg;
    angle_t            amin_reg, amax_reg;
    logic [AXIS_W-1:0] dband_reg;
    logic [TIME_W-1:0] period_reg;
    logic [MASK_W-1:0] mask_reg;

    // Captured request.
    func_t             func_reg;
    logic [SEL_W-1:0]  sel_reg;
    angle_t            pos_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              joy_reg, hold_reg, rst_reg;
    logic [AXIS_W-1:0] front_reg, rear_reg;

    // Arithmetic registers.
    logic [RDT_W-1:0]    rdt_reg;
    logic [PART_W+15:0]  lo_reg, hi_reg;
    angle_t              fd_reg, rd_reg;
    logic [STEP_W-1:0]   step_reg;

    // Block state.
    angle_t            measured_reg [JOINTS];
    angle_t            targets_reg  [JOINTS];
    logic [JOINTS-1:0] reported_reg;
    logic              init_reg, hold_prev_reg, dirty_reg, send_reg;
    logic [TIME_W-1:0] since_reg;

    angle_t            measured_next [JOINTS];
    angle_t            targets_next  [JOINTS];
    angle_t            new_target    [JOINTS];
    logic [JOINTS-1:0] reported_next;
    logic              init_next, hold_prev_next, dirty_next, send_next;
    logic [TIME_W-1:0] since_next;

    logic [DT_W-1:0]     dt;
    logic [AXIS_W-1:0]   front_mag, rear_mag;
    logic                front_dz, rear_dz;
    logic [AXIS_W-1:0]   mul_a;
    logic [DT_W-1:0]     mul_b;
    logic [RDT_W-1:0]    mul_p;
    logic [50:0]         jog_sum;
    logic [RDT_W:0]      step_sum;
    logic [TIME_W:0]     since_sum;

    function automatic logic signed [16:0] to_phys(input logic m, input angle_t v);
        logic signed [16:0] e;
        e = {v[ANGLE_W-1], v};
        return m ? -e : e;
    endfunction

    function automatic logic signed [17:0] move_to_zero(input logic signed [16:0] cur,
                                                        input logic [STEP_W-1:0] step);
        logic signed [17:0] c;
        logic signed [17:0] s;
        logic signed [17:0] n;
        c = {cur[16], cur};
        s = $signed({3'b000, step});
        if (c < 0) begin
            n = c + s;
            return (n > 0) ? 18'sd0 : n;
        end else begin
            n = c - s;
            return (n < 0) ? 18'sd0 : n;
        end
    endfunction

    function automatic angle_t set_phys(input logic m, input logic signed [17:0] p,
                                        input angle_t lo, input angle_t hi);
        logic signed [17:0] c;
        logic signed [17:0] b;
        c = p;
        if (c > $signed({{2{hi[ANGLE_W-1]}}, hi})) c = {{2{hi[ANGLE_W-1]}}, hi};
        if (c < $signed({{2{lo[ANGLE_W-1]}}, lo})) c = {{2{lo[ANGLE_W-1]}}, lo};
        b = m ? -c : c;
        if (b > 18'sd32767) b = 18'sd32767;
        return b[ANGLE_W-1:0];
    endfunction

    function automatic angle_t jog_delta(input logic neg, input logic dz,
                                         input logic [AXIS_W-1:0] mag);
        angle_t d;
        d = $signed(mag);
        if (dz) return '0;
        return neg ? -d : d;
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RST;
            amin_reg   <= AMIN_RST;
            amax_reg   <= AMAX_RST;
            dband_reg  <= DBAND_RST;
            period_reg <= PERIOD_RST;
            mask_reg   <= MASK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RATE:        rate_reg   <= cfg_data[RATE_W-1:0];
                REG_ANGLE_MIN:   amin_reg   <= $signed(cfg_data[ANGLE_W-1:0]);
                REG_ANGLE_MAX:   amax_reg   <= $signed(cfg_data[ANGLE_W-1:0]);
                REG_DEAD_BAND:   dband_reg  <= cfg_data[AXIS_W-1:0];
                REG_SEND_PERIOD: period_reg <= cfg_data[TIME_W-1:0];
                REG_MIRROR_MASK: mask_reg   <= cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture; tdata fields from the lowest bit up.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= func_t'(s_tuser[0]);
            sel_reg     <= s_tdata[1:0];
            pos_reg     <= $signed(s_tdata[17:2]);
            elapsed_reg <= s_tdata[39:18];
            joy_reg     <= s_tdata[40];
            front_reg   <= s_tdata[56:41];
            rear_reg    <= s_tdata[72:57];
            hold_reg    <= s_tdata[73];
            rst_reg     <= s_tdata[74];
        end
    end

    always_comb begin
        if (elapsed_reg == '0 || elapsed_reg > DT_LIMIT) begin
            dt = DT_DEFAULT;
        end else begin
            dt = elapsed_reg[DT_W-1:0];
        end
        front_mag = front_reg[AXIS_W-1] ? (~front_reg + 16'd1) : front_reg;
        rear_mag  = rear_reg[AXIS_W-1]  ? (~rear_reg + 16'd1)  : rear_reg;
        front_dz  = front_mag < dband_reg;
        rear_dz   = rear_mag < dband_reg;
    end

    // Shared multiplier: rate by dt, then each axis magnitude by both halves.
    always_comb begin
        case (cmd.mul_op)
            MUL_RDT: begin
                mul_a = rate_reg;
                mul_b = dt;
            end
            MUL_FLO: begin
                mul_a = front_mag;
                mul_b = {1'b0, rdt_reg[PART_W-1:0]};
            end
            MUL_FHI: begin
                mul_a = front_mag;
                mul_b = {1'b0, rdt_reg[RDT_W-1:PART_W]};
            end
            MUL_RLO: begin
                mul_a = rear_mag;
                mul_b = {1'b0, rdt_reg[PART_W-1:0]};
            end
            MUL_RHI: begin
                mul_a = rear_mag;
                mul_b = {1'b0, rdt_reg[RDT_W-1:PART_W]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p    = mul_a * mul_b;
        jog_sum  = {1'b0, hi_reg, {PART_W{1'b0}}} + {18'd0, lo_reg} + (51'd1 << 34);
        step_sum = {1'b0, rdt_reg} + (35'd1 << 19);
    end

    always_ff @(posedge aclk) begin
        case (cmd.mul_op) inside
            MUL_RDT:          rdt_reg <= mul_p;
            MUL_FLO, MUL_RLO: lo_reg  <= mul_p[PART_W+15:0];
            MUL_FHI, MUL_RHI: hi_reg  <= mul_p[PART_W+15:0];
            default: begin
            end
        endcase
        if (cmd.front_sum) begin
            fd_reg   <= jog_delta(front_reg[AXIS_W-1], front_dz, jog_sum[50:35]);
            step_reg <= step_sum[RDT_W:20];
        end
        if (cmd.rear_sum) begin
            rd_reg <= jog_delta(rear_reg[AXIS_W-1], rear_dz, jog_sum[50:35]);
        end
    end

    // Candidate target of each joint for a reset slew or a jog.
    always_comb begin
        for (int j = 0; j < JOINTS; j++) begin
            if (rst_reg) begin
                new_target[j] = set_phys(mask_reg[j],
                    move_to_zero(to_phys(mask_reg[j], targets_reg[j]), step_reg),
                    amin_reg, amax_reg);
            end else begin
                new_target[j] = set_phys(mask_reg[j],
                    18'(to_phys(mask_reg[j], targets_reg[j]))
                    + 18'((j < 2) ? fd_reg : rd_reg),
                    amin_reg, amax_reg);
            end
        end
    end

    always_comb begin
        logic hold, rst, changed, force_send;
        hold       = joy_reg && hold_reg;
        rst        = joy_reg && rst_reg;
        changed    = 1'b0;
        force_send = 1'b0;
        for (int j = 0; j < JOINTS; j++) begin
            measured_next[j] = measured_reg[j];
            targets_next[j]  = targets_reg[j];
        end
        reported_next  = reported_reg;
        init_next      = init_reg;
        hold_prev_next = hold_prev_reg;
        dirty_next     = dirty_reg;
        send_next      = 1'b0;
        since_sum      = {1'b0, since_reg} + {1'b0, elapsed_reg};
        since_next     = since_reg;
        if (func_reg == FUNC_REPORT) begin
            measured_next[sel_reg] = pos_reg;
            reported_next[sel_reg] = 1'b1;
            if (!init_reg && (&reported_next)) begin
                for (int j = 0; j < JOINTS; j++) begin
                    targets_next[j] = measured_next[j];
                end
                init_next = 1'b1;
            end
        end else begin
            since_next = (since_sum > {1'b0, TIME_MAX}) ? TIME_MAX
                                                         : since_sum[TIME_W-1:0];
            if (init_reg) begin
                if (hold && !hold_prev_reg) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        targets_next[j] = measured_reg[j];
                    end
                    changed    = 1'b1;
                    force_send = 1'b1;
                end else if (rst) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        targets_next[j] = new_target[j];
                    end
                    changed = 1'b1;
                end else if (joy_reg) begin
                    if (fd_reg != '0) begin
                        targets_next[0] = new_target[0];
                        targets_next[1] = new_target[1];
                        changed         = 1'b1;
                    end
                    if (rd_reg != '0) begin
                        targets_next[2] = new_target[2];
                        targets_next[3] = new_target[3];
                        changed         = 1'b1;
                    end
                end
                hold_prev_next = hold;
                dirty_next     = dirty_reg || changed;
                if (dirty_next && (force_send || since_next >= period_reg)) begin
                    send_next  = 1'b1;
                    dirty_next = 1'b0;
                    since_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINTS; j++) begin
                measured_reg[j] <= '0;
                targets_reg[j]  <= '0;
            end
            reported_reg  <= '0;
            init_reg      <= 1'b0;
            hold_prev_reg <= 1'b0;
            dirty_reg     <= 1'b0;
            send_reg      <= 1'b0;
            since_reg     <= '0;
        end else if (cmd.commit) begin
            for (int j = 0; j < JOINTS; j++) begin
                measured_reg[j] <= measured_next[j];
                targets_reg[j]  <= targets_next[j];
            end
            reported_reg  <= reported_next;
            init_reg      <= init_next;
            hold_prev_reg <= hold_prev_next;
            dirty_reg     <= dirty_next;
            send_reg      <= send_next;
            since_reg     <= since_next;
        end
    end

    assign m_tdata = {targets_reg[3], targets_reg[2], targets_reg[1], targets_reg[0]};
    assign m_tuser = {init_reg, send_reg};

    a_init_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |=> init_reg)
        else $error("initialised flag fell");

    a_init_needs_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(init_reg) |-> (&reported_reg))
        else $error("targets initialised before all joints reported");

    a_send_after_init: assert property (@(posedge aclk) disable iff (!aresetn)
        send_reg |-> init_reg)
        else $error("command issued before initialisation");

endmodule

/* sv/jog_setpoint_integrator_top.sv */
// ----------------------------------------------------------------------------
// Jog setpoint integrator
// Turns jog, hold and reset commands into four joint position setpoints
// with limits, mirroring and a minimum command period.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Contents
//  s_*       in         s_tvalid/s_tready   one tick or position report
//  m_*       out        m_tvalid/m_tready   send flag, ready flag, targets
//  cfg_*     in         cfg_valid/cfg_ready register index and write data
//
//  A control tick passes through the five products of the single shared
//  16 by 18 bit multiplier and one rounding step before the apply step;
//  a position report goes straight to the apply step.
//  One request is in flight at a time; the next is accepted while the
//  previous result still waits in the output register.
//  A stalled output holds the finished request in its apply step.
//  Reset (aresetn low, synchronous) clears the block state and loads the
//  register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module jog_setpoint_integrator_top
    import jsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // joint_sel, joint_position, elapsed, joy_valid, front_axis_value,
    // rear_axis_value, hold_btn, reset_btn, zero padding
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_fr, target_fl, target_br, target_bl
    output logic [M_TDATA_W-1:0]  m_tdata,
    // send, ready_res
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    jsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (func_t'(s_tuser[0])),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    jsi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* tb/jsi_setpoint_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jog setpoint integrator checker
// Watches the request, result and register channels of the integrator and
// keeps its own copy of the measurements, targets, timers and settings.
// Every accepted request is turned into the expected result, which is held
// in order and compared field by field with each result the block hands out.
// ----------------------------------------------------------------------------
module jsi_setpoint_checker
    import jsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    outstanding
);

    typedef struct packed {
        logic                            snd;
        logic                            rdy;
        logic [JOINTS-1:0][ANGLE_W-1:0] tg;
    } setpoint_t;

    setpoint_t setpoint_queue[$];
    int        fails = 0;
    int        waiting = 0;
    int        result_no = 0;

    int          rate_q;
    int          amin_q;
    int          amax_q;
    int          dband_q;
    int          period_q;
    logic [3:0]  mask_q;

    int          meas[JOINTS];
    logic        seen[JOINTS];
    int          tgt[JOINTS];
    logic        loaded;
    logic        hold_q;
    logic        dirty_q;
    int          since_q;

    assign mismatch_count = fails;
    assign outstanding    = waiting;

    task automatic note_mismatch(input string msg);
        fails++;
        $display("%0t: %s", $realtime, msg);
    endtask

    function automatic int mirrored(input int j, input int v);
        return mask_q[j] ? -v : v;
    endfunction

    function automatic void place(input int j, input int p);
        int v;
        if (p > amax_q) p = amax_q;
        if (p < amin_q) p = amin_q;
        v = mirrored(j, p);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        tgt[j] = v;
    endfunction

    function automatic int toward_zero(input int cur, input int slew);
        int n;
        if (cur < 0) begin
            n = cur + slew;
            return (n > 0) ? 0 : n;
        end
        n = cur - slew;
        return (n < 0) ? 0 : n;
    endfunction

    function automatic int jog_step(input int axis, input int dt);
        int      mag;
        int      d;
        longint  prod;
        mag = (axis < 0) ? -axis : axis;
        if (mag < dband_q) return 0;
        prod = longint'(mag) * longint'(rate_q) * longint'(dt);
        d = int'((prod + (longint'(1) << 34)) >>> 35);
        return (axis < 0) ? -d : d;
    endfunction

    function automatic setpoint_t integrate_request(input logic is_report,
                                                    input logic [S_TDATA_W-1:0] d);
        logic [1:0] sel;
        int         pos;
        int         elapsed_v;
        int         dt;
        int         slew;
        int         fd;
        int         rd;
        int         fax;
        int         rax;
        logic       joy;
        logic       hold_now;
        logic       zero_now;
        logic       changed;
        logic       forced;
        logic       send_now;
        setpoint_t  r;
        sel       = d[1:0];
        pos       = int'($signed(d[17:2]));
        elapsed_v = int'(d[39:18]);
        joy       = d[40];
        fax       = int'($signed(d[56:41]));
        rax       = int'($signed(d[72:57]));
        hold_now  = joy & d[73];
        zero_now  = joy & d[74];
        send_now  = 1'b0;
        if (is_report) begin
            meas[sel] = pos;
            seen[sel] = 1'b1;
            if (!loaded && seen[0] && seen[1] && seen[2] && seen[3]) begin
                for (int j = 0; j < JOINTS; j++) tgt[j] = meas[j];
                loaded = 1'b1;
            end
        end else begin
            dt = (elapsed_v == 0 || elapsed_v > int'(DT_LIMIT)) ?
                 int'(DT_DEFAULT) : elapsed_v;
            since_q = since_q + elapsed_v;
            if (since_q > int'(TIME_MAX)) since_q = int'(TIME_MAX);
            if (loaded) begin
                changed = 1'b0;
                forced  = 1'b0;
                if (hold_now && !hold_q) begin
                    for (int j = 0; j < JOINTS; j++) tgt[j] = meas[j];
                    changed = 1'b1;
                    forced  = 1'b1;
                end else if (zero_now) begin
                    slew = int'((longint'(rate_q) * longint'(dt) + (longint'(1) << 19)) >>> 20);
                    for (int j = 0; j < JOINTS; j++) begin
                        place(j, toward_zero(mirrored(j, tgt[j]), slew));
                    end
                    changed = 1'b1;
                end else if (joy) begin
                    fd = jog_step(fax, dt);
                    rd = jog_step(rax, dt);
                    if (fd != 0) begin
                        place(0, mirrored(0, tgt[0]) + fd);
                        place(1, mirrored(1, tgt[1]) + fd);
                        changed = 1'b1;
                    end
                    if (rd != 0) begin
                        place(2, mirrored(2, tgt[2]) + rd);
                        place(3, mirrored(3, tgt[3]) + rd);
                        changed = 1'b1;
                    end
                end
                hold_q = hold_now;
                if (changed) dirty_q = 1'b1;
                if (dirty_q && (forced || since_q >= period_q)) begin
                    send_now = 1'b1;
                    dirty_q  = 1'b0;
                    since_q  = 0;
                end
            end
        end
        r.snd = send_now;
        r.rdy = loaded;
        for (int j = 0; j < JOINTS; j++) r.tg[j] = tgt[j][ANGLE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        setpoint_t want;
        if (!aresetn) begin
            rate_q   = int'(RATE_RST);
            amin_q   = int'(AMIN_RST);
            amax_q   = int'(AMAX_RST);
            dband_q  = int'(DBAND_RST);
            period_q = int'(PERIOD_RST);
            mask_q   = MASK_RST;
            for (int j = 0; j < JOINTS; j++) begin
                meas[j] = 0;
                seen[j] = 1'b0;
                tgt[j]  = 0;
            end
            loaded  = 1'b0;
            hold_q  = 1'b0;
            dirty_q = 1'b0;
            since_q = 0;
            setpoint_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                result_no++;
                if (setpoint_queue.size() == 0) begin
                    note_mismatch($sformatf("result %0d with nothing expected: tuser %b tdata %h",
                                            result_no, m_tuser, m_tdata));
                end else begin
                    want = setpoint_queue.pop_front();
                    if (m_tuser[0] !== want.snd) begin
                        note_mismatch($sformatf("result %0d send: got %b, expected %b",
                                                result_no, m_tuser[0], want.snd));
                    end
                    if (m_tuser[1] !== want.rdy) begin
                        note_mismatch($sformatf("result %0d ready: got %b, expected %b",
                                                result_no, m_tuser[1], want.rdy));
                    end
                    for (int j = 0; j < JOINTS; j++) begin
                        if (m_tdata[ANGLE_W*j +: ANGLE_W] !== want.tg[j]) begin
                            note_mismatch($sformatf("result %0d target %0d: got %h, expected %h",
                                                    result_no, j,
                                                    m_tdata[ANGLE_W*j +: ANGLE_W], want.tg[j]));
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RATE:        rate_q   = int'(cfg_data[RATE_W-1:0]);
                    REG_ANGLE_MIN:   amin_q   = int'($signed(cfg_data[ANGLE_W-1:0]));
                    REG_ANGLE_MAX:   amax_q   = int'($signed(cfg_data[ANGLE_W-1:0]));
                    REG_DEAD_BAND:   dband_q  = int'(cfg_data[AXIS_W-1:0]);
                    REG_SEND_PERIOD: period_q = int'(cfg_data[TIME_W-1:0]);
                    REG_MIRROR_MASK: mask_q   = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                setpoint_queue.insert(setpoint_queue.size(),
                                      integrate_request(s_tuser[0] == FUNC_REPORT, s_tdata));
            end
        end
        waiting <= setpoint_queue.size();
    end

endmodule

/* tb/tb_jog_setpoint_integrator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jog setpoint integrator testbench
// Drives position reports and control ticks through the request channel in
// bursts, stalls the result channel on its own pattern and rewrites the
// settings between phases. A directed opening covers the start-up, hold,
// slew, deadzone, rounding, limit and mirroring corners; random phases follow.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_jog_setpoint_integrator_top;
    import jsi_pkg::*;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    mismatch_count;
    int                    outstanding;

    int                    rx_mode   = 0;
    logic [6:0]            rx_count  = '0;
    bit                    bursty    = 1'b0;
    int                    burst_left = 0;
    bit                    hold_level = 1'b0;
    int                    dead_now  = int'(DBAND_RST);

    jog_setpoint_integrator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jsi_setpoint_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        rx_count <= rx_count + 7'd1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= !(rx_count[5:3] == 3'd6 || rx_count[1:0] == 2'd3);
        endcase
    end

    task automatic push_request(input func_t f, input logic [S_TDATA_W-1:0] d);
        if (bursty && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] elapsed, input logic joy,
                             input logic [AXIS_W-1:0] front, input logic [AXIS_W-1:0] rear,
                             input logic hold, input logic zero_btn);
        logic [17:0] noise;
        noise = 18'($urandom);
        push_request(FUNC_TICK, {5'b0, zero_btn, hold, rear, front, joy, elapsed, noise});
    endtask

    task automatic send_report(input logic [1:0] sel, input logic [ANGLE_W-1:0] pos);
        logic [56:0] noise;
        noise = {25'($urandom), 32'($urandom)};
        push_request(FUNC_REPORT, {5'b0, noise, pos, sel});
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input int rate, input int amin, input int amax,
                                 input int dband, input int period, input int mask);
        cfg_write(REG_RATE,        22'(rate & 16'hFFFF));
        cfg_write(REG_ANGLE_MIN,   22'(amin & 16'hFFFF));
        cfg_write(REG_ANGLE_MAX,   22'(amax & 16'hFFFF));
        cfg_write(REG_DEAD_BAND,   22'(dband & 16'hFFFF));
        cfg_write(REG_SEND_PERIOD, 22'(period));
        cfg_write(REG_MIRROR_MASK, 22'(mask & 4'hF));
        cfg_valid <= 1'b0;
        dead_now = dband;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [TIME_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TIME_W'($urandom);
            2:       return TIME_W'($urandom_range(209714, 209716));
            default: return TIME_W'($urandom_range(5000, 60000));
        endcase
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis();
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            2: begin
                v = dead_now - 2 + $urandom_range(0, 4);
                if (v > 32767) v = 32767;
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            default: v = int'($signed(16'($urandom)));
        endcase
        return AXIS_W'(v);
    endfunction

    task automatic random_request();
        if ($urandom_range(0, 99) < 8) begin
            send_report(2'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(0, 9) == 0) hold_level = !hold_level;
            send_tick(pick_elapsed(), $urandom_range(0, 19) != 0, pick_axis(), pick_axis(),
                      hold_level, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        int rate;
        int amin;
        int amax;
        int period;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ticks before start-up only advance the send timer.
        send_tick(22'd5, 1'b1, 16'h7FFF, 16'h0000, 1'b1, 1'b0);
        send_tick(TIME_MAX, 1'b1, 16'h0000, 16'h8000, 1'b0, 1'b1);
        send_report(2'd0, 16'h7FFF);
        send_report(2'd1, 16'h8000);
        send_report(2'd2, 16'd100);
        send_report(2'd3, 16'hFF9C);
        send_report(2'd2, 16'd2000);
        send_tick(22'd1000, 1'b0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
        send_tick(22'd1000, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0);
        send_tick(22'd0, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_tick(22'd209716, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_tick(22'd209715, 1'b1, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
        send_tick(22'd20000, 1'b1, 16'd6553, 16'hE666, 1'b0, 1'b0);
        send_tick(22'd1, 1'b1, 16'd6554, 16'h0000, 1'b0, 1'b0);
        send_tick(TIME_MAX, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
        send_tick(22'd300000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
        settle();

        // Widest limits and full mirroring reach the mirror overflow case.
        load_settings(65535, -32768, 32767, 0, 0, 15);
        send_tick(22'd100, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0);
        send_tick(22'd100, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_tick(22'd209715, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0);
        send_tick(22'd209715, 1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
        send_tick(22'd20000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
        settle();

        // Crossed limits pin every slewed target to the lower limit.
        load_settings(0, 100, -100, 32768, 4194303, 0);
        send_tick(22'd20000, 1'b1, 16'h8000, 16'h0000, 1'b0, 1'b0);
        send_tick(22'd20000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_tick(22'd20000, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0);
        settle();

        for (int p = 0; p < 6; p++) begin
            rate   = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(200, 20000);
            amin   = -$urandom_range(0, 32768);
            amax   = $urandom_range(0, 32767);
            period = ($urandom_range(0, 3) == 0) ? int'(22'($urandom))
                                                 : $urandom_range(0, 400000);
            if (p == 0) begin
                rate = int'(RATE_RST);
                amin = int'(AMIN_RST);
                amax = int'(AMAX_RST);
            end
            if (p == 4) begin
                rate = int'(16'($urandom));
                amin = $urandom_range(0, 2000);
                amax = -$urandom_range(0, 2000);
            end
            load_settings(rate, amin, amax, $urandom_range(0, 12000), period,
                          $urandom_range(0, 15));
            rx_mode = p % 3;
            bursty  = (p % 2) == 1;
            burst_left = 0;
            repeat (300) random_request();
            settle();
        end

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
